// File: hw/rtl/ihs_pkg.sv
// ihs_pkg: shared types and constants of the 802.15.4 header survey block
// used by ihs_layout, ihs_uniq_set and ieee802154_header_survey; no dependencies
package ihs_pkg;

   // default table sizes
   localparam int DEVICE_SLOTS_DEF = 6;
   localparam int PAN_SLOTS_DEF    = 4;

   // header byte positions fit in five bits (last needed byte is at most 16)
   localparam int POS_W = 5;

   // frame and address constants
   localparam logic [7:0]  MIN_FRAME_LEN = 8'd3;
   localparam logic [7:0]  LQI_BYTES     = 8'd2;
   localparam logic [15:0] PAN_BCAST     = 16'hFFFF;
   localparam logic [15:0] PAN_ZERO      = 16'h0000;

   // addressing modes of the frame control field
   localparam logic [1:0] ADDR_MODE_NONE  = 2'd0;
   localparam logic [1:0] ADDR_MODE_SHORT = 2'd2;

   // lengths of header fields in bytes
   localparam logic [7:0] PAN_LEN        = 8'd2;
   localparam logic [7:0] SHORT_ADDR_LEN = 8'd2;
   localparam logic [7:0] LONG_ADDR_LEN  = 8'd8;
   localparam logic [7:0] FIRST_FIELD_AT = 8'd3;

   // header layout derived from the frame control field and the length
   typedef struct packed {
      logic             ok;
      logic             dp_vld;
      logic [POS_W-1:0] dp_at;
      logic             sp_vld;
      logic [POS_W-1:0] sp_at;
      logic             sa_vld;
      logic [POS_W-1:0] sa_at;
      logic [POS_W-1:0] last;
   } layout_type;

   // one result record, lowest field in the lowest bits
   typedef struct packed {
      logic [15:0] new_pan_id;
      logic        new_pan_valid;
      logic [15:0] new_device_addr;
      logic        new_device_valid;
      logic [2:0]  pan_total;
      logic [2:0]  device_total;
      logic [3:0]  type_mask;
      logic [7:0]  peak_rssi;
      logic [15:0] frame_count;
   } rsp_rec_type;

endpackage

// File: hw/rtl/ihs_layout.sv
// ihs_layout: decodes the header layout (field positions and bounds check)
// from the frame control word and the PHY length; uses ihs_pkg
module ihs_layout (
   input  logic [15:0]        control_word,
   input  logic [7:0]         frame_length,
   output ihs_pkg::layout_type layout
);

   logic [1:0] dst_mode;
   logic [1:0] source_mode;
   logic       pan_comp;
   logic [7:0] limit;
   logic [7:0] off;
   logic [7:0] addr_len;
   logic       fail;

   always_comb begin
      dst_mode    = control_word[11:10];
      source_mode = control_word[15:14];
      pan_comp    = control_word[6];
      limit    = (frame_length >= ihs_pkg::LQI_BYTES) ? frame_length - ihs_pkg::LQI_BYTES
                                                      : 8'd0;
      addr_len = (dst_mode == ihs_pkg::ADDR_MODE_SHORT) ? ihs_pkg::SHORT_ADDR_LEN
                                                        : ihs_pkg::LONG_ADDR_LEN;
      off      = ihs_pkg::FIRST_FIELD_AT;
      fail     = 1'b0;
      layout   = '0;
      layout.last = ihs_pkg::POS_W'(1);

      // destination pan and address
      if (dst_mode != ihs_pkg::ADDR_MODE_NONE) begin
         if (off + ihs_pkg::PAN_LEN > limit) begin
            fail = 1'b1;
         end else begin
            layout.dp_vld = 1'b1;
            layout.dp_at  = off[ihs_pkg::POS_W-1:0];
            layout.last   = ihs_pkg::POS_W'(off + 8'd1);
            off = off + ihs_pkg::PAN_LEN;
            if (off + addr_len > limit) begin
               fail = 1'b1;
            end else begin
               off = off + addr_len;
            end
         end
      end

      // source pan unless compressed, then short source address
      if (!fail && source_mode != ihs_pkg::ADDR_MODE_NONE) begin
         if (!pan_comp) begin
            if (off + ihs_pkg::PAN_LEN > limit) begin
               fail = 1'b1;
            end else begin
               layout.sp_vld = 1'b1;
               layout.sp_at  = off[ihs_pkg::POS_W-1:0];
               layout.last   = ihs_pkg::POS_W'(off + 8'd1);
               off = off + ihs_pkg::PAN_LEN;
            end
         end
         if (!fail && source_mode == ihs_pkg::ADDR_MODE_SHORT) begin
            if (off + ihs_pkg::SHORT_ADDR_LEN > limit) begin
               fail = 1'b1;
            end else begin
               layout.sa_vld = 1'b1;
               layout.sa_at  = off[ihs_pkg::POS_W-1:0];
               layout.last   = ihs_pkg::POS_W'(off + 8'd1);
            end
         end
      end

      layout.ok = !fail;
   end

endmodule

// File: hw/rtl/ihs_uniq_set.sv
// ihs_uniq_set: small set of distinct 16-bit values with a fill count,
// parallel lookup and append; uses ihs_pkg for the default size
module ihs_uniq_set #(
   parameter int SLOTS = ihs_pkg::DEVICE_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       add_req,
   input  logic [15:0]                add_value,
   output logic                       added,
   output logic [$clog2(SLOTS+1)-1:0] fill_next
);

   localparam int FILL_W = $clog2(SLOTS + 1);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [15:0]       entry_ff [SLOTS];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              hit;
   logic              write_en;

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if ((i < int'(fill_ff)) && (entry_ff[i] == add_value)) begin
            hit = 1'b1;
         end
      end
      write_en = add_req && !hit && (fill_ff < FILL_W'(SLOTS));
      if (clear) begin
         fill_in = '0;
      end else if (write_en) begin
         fill_in = fill_ff + FILL_W'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   assign added     = write_en;
   assign fill_next = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // entries need no reset, only those below the fill are looked at
   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff[fill_ff[IDX_W-1:0]] <= add_value;
      end
   end

endmodule

// File: hw/rtl/ieee802154_header_survey.sv
// ieee802154_header_survey: 802.15.4 receive header parser and survey record
// depends on ihs_pkg, ihs_layout and ihs_uniq_set
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  tuser {frame_start, action},
//                                               tdata {rssi, data_byte}
//   rsp_      out        rsp_tvalid/rsp_tready  tdata survey record after each request
//
// every request gives exactly one response, one request per cycle sustained
// while rsp_tready is high; a request is parsed in the cycle it is accepted
// and its record lands in a two-entry output queue (output register plus skid)
// req_tready drops only when both queue entries hold untaken responses
// reset (synchronous, active high) empties the record and the queue
module ieee802154_header_survey #(
   parameter int DEVICE_SLOTS = ihs_pkg::DEVICE_SLOTS_DEF,
   parameter int PAN_SLOTS    = ihs_pkg::PAN_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [0] action, [1] frame_start
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] rssi
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [15:0] frame_count, [23:16] peak_rssi,
                                    // [27:24] type_mask, [30:28] device_total,
                                    // [33:31] pan_total, [34] new_device_valid,
                                    // [50:35] new_device_addr, [51] new_pan_valid,
                                    // [67:52] new_pan_id, [71:68] zero
);

   localparam int DEV_FILL_W = $clog2(DEVICE_SLOTS + 1);
   localparam int PAN_FILL_W = $clog2(PAN_SLOTS + 1);

   // parser phase codes
   localparam logic PHASE_IDLE = 1'b0;
   localparam logic PHASE_WALK = 1'b1;

   // request fields
   logic              req_fire;
   logic              action;
   logic              frame_start;
   logic [7:0]        data_byte;
   logic signed [7:0] rssi;

   // survey and parser state
   logic [15:0]       frames_ff,  frames_in;
   logic signed [7:0] best_ff,    best_in;
   logic [3:0]        types_ff,   types_in;
   logic [7:0]        pos_ff,     pos_in;
   logic [7:0]        len_ff,     len_in;
   logic [15:0]       cw_ff,      cw_in;
   logic [15:0]       dpan_ff,    dpan_in;
   logic [15:0]       span_ff,    span_in;
   logic [7:0]        hold_ff,    hold_in;
   logic              phase_ff,   phase_in;

   // header walk helpers
   logic [15:0]         cw_cur;
   ihs_pkg::layout_type layout;
   logic [15:0]         word;
   logic [15:0]         pan_pick;
   logic                clear;
   logic                dev_add;
   logic                pan_add;
   logic                dev_added;
   logic                pan_added;
   logic [DEV_FILL_W-1:0] dev_fill;
   logic [PAN_FILL_W-1:0] pan_fill;
   ihs_pkg::rsp_rec_type  rec;

   // output queue
   ihs_pkg::rsp_rec_type head_ff, skid_ff;
   logic                 head_vld_ff, skid_vld_ff;
   logic                 rsp_fire;

   assign action      = req_tuser[0];
   assign frame_start = req_tuser[1];
   assign data_byte   = req_tdata[7:0];
   assign rssi        = req_tdata[15:8];

   assign req_tready = !skid_vld_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = head_vld_ff && rsp_tready;

   // the frame control high byte counts already on the byte that carries it
   assign cw_cur = (pos_ff == 8'd1) ? {data_byte, cw_ff[7:0]} : cw_ff;

   ihs_layout u_layout (
      .control_word (cw_cur),
      .frame_length (len_ff),
      .layout       (layout)
   );

   always_comb begin
      frames_in = frames_ff;
      best_in   = best_ff;
      types_in  = types_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      cw_in     = cw_ff;
      dpan_in   = dpan_ff;
      span_in   = span_ff;
      hold_in   = hold_ff;
      phase_in  = phase_ff;
      clear     = 1'b0;
      dev_add   = 1'b0;
      pan_add   = 1'b0;
      word      = {data_byte, hold_ff};
      pan_pick  = ihs_pkg::PAN_BCAST;

      if (req_fire) begin
         if (action) begin
            // clear the record and drop any frame in progress
            clear     = 1'b1;
            frames_in = '0;
            best_in   = -8'sd128;
            types_in  = '0;
            pos_in    = '0;
            len_in    = '0;
            cw_in     = '0;
            dpan_in   = ihs_pkg::PAN_BCAST;
            span_in   = ihs_pkg::PAN_BCAST;
            hold_in   = '0;
            phase_in  = PHASE_IDLE;
         end else if (frame_start) begin
            // length byte: short frames are ignored, a new one aborts the old
            phase_in = PHASE_IDLE;
            if (data_byte >= ihs_pkg::MIN_FRAME_LEN) begin
               len_in   = data_byte;
               pos_in   = '0;
               cw_in    = '0;
               dpan_in  = ihs_pkg::PAN_BCAST;
               span_in  = ihs_pkg::PAN_BCAST;
               hold_in  = '0;
               phase_in = PHASE_WALK;
               if (frames_ff != 16'hFFFF) begin
                  frames_in = frames_ff + 16'd1;
               end
               if (rssi > best_ff) begin
                  best_in = rssi;
               end
            end
         end else if (phase_ff == PHASE_WALK) begin
            if (pos_ff == 8'd0) begin
               // frame control low byte carries the frame type
               cw_in = {cw_ff[15:8], data_byte};
               if (!data_byte[2]) begin
                  types_in = types_ff | (4'b0001 << data_byte[1:0]);
               end
            end else begin
               cw_in = cw_cur;
               if (!layout.ok) begin
                  phase_in = PHASE_IDLE;
               end else begin
                  if ((layout.dp_vld && pos_ff == 8'(layout.dp_at)) ||
                      (layout.sp_vld && pos_ff == 8'(layout.sp_at)) ||
                      (layout.sa_vld && pos_ff == 8'(layout.sa_at))) begin
                     hold_in = data_byte;
                  end
                  if (layout.dp_vld && pos_ff == 8'(layout.dp_at) + 8'd1) begin
                     dpan_in = word;
                  end
                  if (layout.sp_vld && pos_ff == 8'(layout.sp_at) + 8'd1) begin
                     span_in = word;
                  end
                  if (pos_ff == 8'(layout.last)) begin
                     // last header byte: store address and pan right here
                     dev_add = layout.sa_vld;
                     if (cw_cur[15:14] != ihs_pkg::ADDR_MODE_NONE && cw_cur[6]) begin
                        span_in = dpan_in;
                     end
                     pan_pick = (dpan_in != ihs_pkg::PAN_BCAST) ? dpan_in : span_in;
                     pan_add  = (pan_pick != ihs_pkg::PAN_BCAST) &&
                                (pan_pick != ihs_pkg::PAN_ZERO);
                     phase_in = PHASE_IDLE;
                  end
               end
            end
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   ihs_uniq_set #(
      .SLOTS (DEVICE_SLOTS)
   ) u_dev_set (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .add_req   (dev_add),
      .add_value (word),
      .added     (dev_added),
      .fill_next (dev_fill)
   );

   ihs_uniq_set #(
      .SLOTS (PAN_SLOTS)
   ) u_pan_set (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .add_req   (pan_add),
      .add_value (pan_pick),
      .added     (pan_added),
      .fill_next (pan_fill)
   );

   // record as it stands after this request
   always_comb begin
      rec.frame_count      = frames_in;
      rec.peak_rssi        = best_in;
      rec.type_mask        = types_in;
      rec.device_total     = 3'(dev_fill);
      rec.pan_total        = 3'(pan_fill);
      rec.new_device_valid = dev_added;
      rec.new_device_addr  = dev_added ? word : 16'h0000;
      rec.new_pan_valid    = pan_added;
      rec.new_pan_id       = pan_added ? pan_pick : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= '0;
         best_ff   <= -8'sd128;
         types_ff  <= '0;
         pos_ff    <= '0;
         len_ff    <= '0;
         cw_ff     <= '0;
         dpan_ff   <= ihs_pkg::PAN_BCAST;
         span_ff   <= ihs_pkg::PAN_BCAST;
         hold_ff   <= '0;
         phase_ff  <= PHASE_IDLE;
      end else begin
         frames_ff <= frames_in;
         best_ff   <= best_in;
         types_ff  <= types_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         cw_ff     <= cw_in;
         dpan_ff   <= dpan_in;
         span_ff   <= span_in;
         hold_ff   <= hold_in;
         phase_ff  <= phase_in;
      end
   end

   // output queue valid bits: head is shown, skid catches a stalled second response
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_fire) begin
         head_vld_ff <= skid_vld_ff || req_fire;
         skid_vld_ff <= skid_vld_ff && req_fire;
      end else if (req_fire) begin
         head_vld_ff <= 1'b1;
         skid_vld_ff <= head_vld_ff;
      end
   end

   // output queue payload
   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         if (skid_vld_ff) begin
            head_ff <= skid_ff;
            if (req_fire) begin
               skid_ff <= rec;
            end
         end else if (req_fire) begin
            head_ff <= rec;
         end
      end else if (req_fire) begin
         if (head_vld_ff) begin
            skid_ff <= rec;
         end else begin
            head_ff <= rec;
         end
      end
   end

   assign rsp_tvalid = head_vld_ff;
   assign rsp_tdata  = {4'b0000, head_ff};

endmodule

// File: test/ieee802154_header_survey_tb.sv
`timescale 1ns / 1ps
// ieee802154_header_survey_tb: self-checking bench for the 802.15.4 header survey block
// drives request bytes with random gaps and backpressure, checks every record response
// depends on ihs_pkg and ieee802154_header_survey
module ieee802154_header_survey_tb;

   // request codes and frame fields used by the stimulus and the survey tracker
   localparam logic ACT_BYTE  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   localparam logic [2:0] FTYPE_BEACON = 3'd0;
   localparam logic [2:0] FTYPE_DATA   = 3'd1;
   localparam logic [2:0] FTYPE_CMD    = 3'd3;
   localparam logic [2:0] FTYPE_RSVD   = 3'd7;

   localparam int NO_FIELD = -1;
   localparam int MAX_REPORTS = 100;

   typedef enum logic {WALK_IDLE, WALK_HEADER} walk_state_type;

   // one queued request with the idling phase it belongs to
   typedef struct {
      logic       act;
      logic       start;
      logic [7:0] octet;
      logic [7:0] rssi;
      int         phase;
      bit         drain_first;
   } survey_req_type;

   // byte positions of the header fields that the walk reads
   typedef struct {
      bit ok;
      int dp_at;
      int sp_at;
      int sa_at;
      int last;
   } hdr_plan_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;    // [0] action, [1] frame_start
   logic [15:0] req_tdata = '0;    // [7:0] data_byte, [15:8] rssi
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // frame_count, peak_rssi, type_mask, device_total,
                                   // pan_total, new_device_valid, new_device_addr,
                                   // new_pan_valid, new_pan_id, zero pad

   ieee802154_header_survey i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // request and response bookkeeping
   survey_req_type       pending_reqs[$];
   ihs_pkg::rsp_rec_type survey_exp_q[$];
   int                   total_reqs = 0;
   int                   reqs_taken = 0;
   int                   error_count = 0;
   bit                   req_accepted = 1'b0;
   int                   cur_phase = 0;
   int                   fill_phase = 0;
   bit                   fill_drain = 1'b0;

   // idle percentages per phase: sender light then heavy, receiver the other way round, neither in the last
   int req_idle_pct[3]  = '{20, 65, 0};
   int rsp_stall_pct[3] = '{65, 20, 0};

   // tracked survey record
   logic [15:0]        cnt_frames;
   logic signed [7:0]  peak_dbm;
   logic [3:0]         type_bits;
   logic [15:0]        dev_list[$];
   logic [15:0]        pan_list[$];
   logic [7:0]         hdr_pos;
   logic [7:0]         phy_len;
   logic [15:0]        fcf_word;
   logic [15:0]        dst_pan_id;
   logic [15:0]        src_pan_id;
   logic [7:0]         lo_byte;
   walk_state_type     walk_st;

   // ---------------------------------------------------------------------------
   // survey tracker
   // ---------------------------------------------------------------------------

   function automatic void clear_survey();
      cnt_frames = '0;
      peak_dbm   = -8'sd128;
      type_bits  = '0;
      dev_list.delete();
      pan_list.delete();
      hdr_pos    = '0;
      phy_len    = '0;
      fcf_word   = '0;
      dst_pan_id = ihs_pkg::PAN_BCAST;
      src_pan_id = ihs_pkg::PAN_BCAST;
      lo_byte    = '0;
      walk_st    = WALK_IDLE;
   endfunction

   function automatic bit in_list(logic [15:0] tab[$], logic [15:0] v);
      foreach (tab[i])
         if (tab[i] == v) return 1'b1;
      return 1'b0;
   endfunction

   // every field must end within length minus the two trailing link quality bytes
   function automatic hdr_plan_type plan_header(logic [15:0] fcf, logic [7:0] flen);
      hdr_plan_type hp;
      int        lim;
      int        off;
      int        alen;
      hp.ok    = 1'b0;
      hp.dp_at = NO_FIELD;
      hp.sp_at = NO_FIELD;
      hp.sa_at = NO_FIELD;
      hp.last  = 1;
      lim = (flen >= ihs_pkg::LQI_BYTES) ? int'(flen) - int'(ihs_pkg::LQI_BYTES) : 0;
      off = int'(ihs_pkg::FIRST_FIELD_AT);
      if (fcf[11:10] != ihs_pkg::ADDR_MODE_NONE) begin
         // modes other than short count as a long destination address
         alen = (fcf[11:10] == ihs_pkg::ADDR_MODE_SHORT) ? int'(ihs_pkg::SHORT_ADDR_LEN)
                                                          : int'(ihs_pkg::LONG_ADDR_LEN);
         if (off + int'(ihs_pkg::PAN_LEN) > lim) return hp;
         hp.dp_at = off;
         hp.last  = off + 1;
         off += int'(ihs_pkg::PAN_LEN);
         if (off + alen > lim) return hp;
         off += alen;
      end
      if (fcf[15:14] != ihs_pkg::ADDR_MODE_NONE) begin
         if (!fcf[6]) begin
            if (off + int'(ihs_pkg::PAN_LEN) > lim) return hp;
            hp.sp_at = off;
            hp.last  = off + 1;
            off += int'(ihs_pkg::PAN_LEN);
         end
         // only a short source address is read
         if (fcf[15:14] == ihs_pkg::ADDR_MODE_SHORT) begin
            if (off + int'(ihs_pkg::SHORT_ADDR_LEN) > lim) return hp;
            hp.sa_at = off;
            hp.last  = off + 1;
         end
      end
      hp.ok = 1'b1;
      return hp;
   endfunction

   // advance the tracked record by one request and return the record it should show
   function automatic ihs_pkg::rsp_rec_type survey_update(logic act, logic start,
                                                          logic [7:0] b,
                                                          logic signed [7:0] rssi);
      ihs_pkg::rsp_rec_type rec;
      hdr_plan_type         hp;
      logic [15:0]          word;
      logic [15:0]          pan;
      int                   p;
      rec = '0;
      p   = int'(hdr_pos);
      if (act == ACT_CLEAR) begin
         clear_survey();
      end else if (start) begin
         // a length byte always aborts the frame in progress
         walk_st = WALK_IDLE;
         if (b >= ihs_pkg::MIN_FRAME_LEN) begin
            phy_len    = b;
            hdr_pos    = '0;
            fcf_word   = '0;
            dst_pan_id = ihs_pkg::PAN_BCAST;
            src_pan_id = ihs_pkg::PAN_BCAST;
            lo_byte    = '0;
            walk_st    = WALK_HEADER;
            if (cnt_frames != 16'hFFFF) cnt_frames = cnt_frames + 16'd1;
            if (rssi > peak_dbm) peak_dbm = rssi;
         end
      end else if (walk_st == WALK_HEADER) begin
         if (p == 0) begin
            fcf_word[7:0] = b;
            // reserved types set no bit
            if (b[2:0] <= FTYPE_CMD) type_bits[b[1:0]] = 1'b1;
         end else begin
            if (p == 1) fcf_word[15:8] = b;
            hp = plan_header(fcf_word, phy_len);
            if (!hp.ok) begin
               walk_st = WALK_IDLE;
            end else begin
               word = {b, lo_byte};
               if (p == hp.dp_at || p == hp.sp_at || p == hp.sa_at) lo_byte = b;
               if (hp.dp_at != NO_FIELD && p == hp.dp_at + 1) dst_pan_id = word;
               if (hp.sp_at != NO_FIELD && p == hp.sp_at + 1) src_pan_id = word;
               // stores land on the last header byte read, not at end of frame
               if (p == hp.last) begin
                  if (hp.sa_at != NO_FIELD && !in_list(dev_list, word) &&
                      dev_list.size() < ihs_pkg::DEVICE_SLOTS_DEF) begin
                     dev_list.push_back(word);
                     rec.new_device_valid = 1'b1;
                     rec.new_device_addr  = word;
                  end
                  if (fcf_word[15:14] != ihs_pkg::ADDR_MODE_NONE && fcf_word[6])
                     src_pan_id = dst_pan_id;
                  pan = (dst_pan_id != ihs_pkg::PAN_BCAST) ? dst_pan_id : src_pan_id;
                  if (pan != ihs_pkg::PAN_BCAST && pan != ihs_pkg::PAN_ZERO &&
                      !in_list(pan_list, pan) && pan_list.size() < ihs_pkg::PAN_SLOTS_DEF) begin
                     pan_list.push_back(pan);
                     rec.new_pan_valid = 1'b1;
                     rec.new_pan_id    = pan;
                  end
                  walk_st = WALK_IDLE;
               end
            end
         end
         hdr_pos = hdr_pos + 8'd1;
      end
      rec.frame_count  = cnt_frames;
      rec.peak_rssi    = peak_dbm;
      rec.type_mask    = type_bits;
      rec.device_total = 3'(dev_list.size());
      rec.pan_total    = 3'(pan_list.size());
      return rec;
   endfunction

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic check_response(logic [71:0] tdata);
      ihs_pkg::rsp_rec_type got;
      ihs_pkg::rsp_rec_type want;
      if (survey_exp_q.size() == 0) begin
         report_mismatch("response with no request outstanding");
         return;
      end
      got  = tdata[67:0];
      want = survey_exp_q.pop_front();
      check_field("frame_count", got.frame_count, want.frame_count);
      check_field("peak_rssi", 16'(got.peak_rssi), 16'(want.peak_rssi));
      check_field("type_mask", 16'(got.type_mask), 16'(want.type_mask));
      check_field("device_total", 16'(got.device_total), 16'(want.device_total));
      check_field("pan_total", 16'(got.pan_total), 16'(want.pan_total));
      check_field("new_device_valid", 16'(got.new_device_valid), 16'(want.new_device_valid));
      check_field("new_device_addr", got.new_device_addr, want.new_device_addr);
      check_field("new_pan_valid", 16'(got.new_pan_valid), 16'(want.new_pan_valid));
      check_field("new_pan_id", got.new_pan_id, want.new_pan_id);
      check_field("pad", 16'(tdata[71:68]), 16'h0000);
   endtask

   // monitor: sample both handshakes at the rising edge
   always @(posedge clock) begin
      req_accepted = 1'b0;
      if (reset) begin
         clear_survey();
      end else begin
         // responses first: a request taken at this edge cannot answer at this edge
         if (rsp_tvalid && rsp_tready) check_response(rsp_tdata);
         if (req_tvalid && req_tready) begin
            survey_exp_q.push_back(survey_update(req_tuser[0], req_tuser[1],
                                                 req_tdata[7:0], req_tdata[15:8]));
            req_accepted = 1'b1;
            reqs_taken++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // driver: change inputs at the falling edge
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin : drive_reqs
      survey_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct[cur_phase]);
         // hold the request on the bus until it is taken
         if (!req_tvalid || req_accepted) begin
            if (pending_reqs.size() == 0 ||
                (pending_reqs[0].drain_first && survey_exp_q.size() != 0) ||
                $urandom_range(0, 99) < req_idle_pct[pending_reqs[0].phase]) begin
               req_tvalid <= 1'b0;
            end else begin
               nxt = pending_reqs.pop_front();
               cur_phase = nxt.phase;
               req_tvalid <= 1'b1;
               req_tuser  <= {nxt.start, nxt.act};
               req_tdata  <= {nxt.rssi, nxt.octet};
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------

   task automatic push_req(logic act, logic start, logic [7:0] octet, logic [7:0] rssi);
      survey_req_type r;
      r.act         = act;
      r.start       = start;
      r.octet       = octet;
      r.rssi        = rssi;
      r.phase       = fill_phase;
      r.drain_first = fill_drain;
      fill_drain    = 1'b0;
      pending_reqs.push_back(r);
   endtask

   // mac byte, rssi is don't-care here so it is random
   task automatic push_byte(logic [7:0] octet);
      push_req(ACT_BYTE, 1'b0, octet, 8'($urandom));
   endtask

   // small pools so that repeats and full tables happen, with 0000, ffff and random ones
   function automatic logic [15:0] pick_pan();
      case ($urandom_range(0, 11))
         0:       return ihs_pkg::PAN_ZERO;
         1:       return ihs_pkg::PAN_BCAST;
         2:       return 16'($urandom);
         default: return 16'hC3A0 + 16'($urandom_range(0, 6));
      endcase
   endfunction

   function automatic logic [15:0] pick_addr();
      case ($urandom_range(0, 11))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'h5C10 + 16'($urandom_range(0, 8));
      endcase
   endfunction

   // a frame with a well-formed header, optionally a length too short for it,
   // optionally cut off somewhere inside the header
   task automatic push_random_frame(bit bad_len, bit cut);
      logic [7:0]  hdr[$];
      logic [15:0] fcf;
      logic [15:0] v;
      int          len;
      int          keep;
      fcf = 16'($urandom);
      fcf[2:0] = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
                                            : 3'($urandom_range(4, 7));
      hdr.push_back(fcf[7:0]);
      hdr.push_back(fcf[15:8]);
      hdr.push_back(8'($urandom));
      if (fcf[11:10] != ihs_pkg::ADDR_MODE_NONE) begin
         v = pick_pan();
         hdr.push_back(v[7:0]);
         hdr.push_back(v[15:8]);
         if (fcf[11:10] == ihs_pkg::ADDR_MODE_SHORT) begin
            v = pick_addr();
            hdr.push_back(v[7:0]);
            hdr.push_back(v[15:8]);
         end else begin
            repeat (8) hdr.push_back(8'($urandom));
         end
      end
      if (fcf[15:14] != ihs_pkg::ADDR_MODE_NONE) begin
         if (!fcf[6]) begin
            v = pick_pan();
            hdr.push_back(v[7:0]);
            hdr.push_back(v[15:8]);
         end
         if (fcf[15:14] == ihs_pkg::ADDR_MODE_SHORT) begin
            v = pick_addr();
            hdr.push_back(v[7:0]);
            hdr.push_back(v[15:8]);
         end else begin
            repeat (8) hdr.push_back(8'($urandom));
         end
      end
      len = hdr.size() + 2 + $urandom_range(0, 8);
      if (bad_len) len = $urandom_range(3, hdr.size() + 1);
      else if ($urandom_range(0, 39) == 0) len = $urandom_range(128, 255);
      push_req(ACT_BYTE, 1'b1, 8'(len), 8'($urandom));
      keep = cut ? $urandom_range(0, hdr.size() - 1) : hdr.size() + $urandom_range(0, 3);
      for (int i = 0; i < keep; i++)
         push_byte((i < hdr.size()) ? hdr[i] : 8'($urandom));
   endtask

   // random traffic: mostly good frames, the rest broken frames, noise and clears
   task automatic push_random_traffic(int goal);
      int pick;
      while (pending_reqs.size() < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) push_random_frame(1'b0, 1'b0);
         else if (pick < 72) push_random_frame(1'b1, 1'b0);
         else if (pick < 82) push_random_frame(1'($urandom), 1'b1);
         else if (pick < 90) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
         else if (pick < 96) push_req(ACT_BYTE, 1'b1, 8'($urandom_range(0, 2)), 8'($urandom));
         else if (pick < 99) push_req(ACT_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom));
         else fill_drain = 1'b1;
      end
   endtask

   initial begin
      // stray byte while idle
      push_req(ACT_BYTE, 1'b0, 8'hFF, 8'h80);
      // too short a frame is ignored
      push_req(ACT_BYTE, 1'b1, 8'h02, 8'h7F);
      // minimal beacon: nothing to read, stores on the fcf high byte; then a byte past it
      push_req(ACT_BYTE, 1'b1, 8'h03, 8'h80);
      push_byte({5'b00000, FTYPE_BEACON});
      push_byte(8'h00);
      push_byte(8'h55);
      // data frame, short addresses with pan compression, peak rssi at top
      push_req(ACT_BYTE, 1'b1, 8'd11, 8'h7F);
      push_byte({5'b01000, FTYPE_DATA});
      push_byte(8'h88);
      push_byte(8'hFF);
      push_byte(8'h34);
      push_byte(8'h12);
      push_byte(8'hFF);
      push_byte(8'hFF);
      push_byte(8'h01);
      push_byte(8'h00);
      // reserved type with long addresses, aborted by a new length byte
      push_req(ACT_BYTE, 1'b1, 8'd20, 8'h01);
      push_byte({5'b00000, FTYPE_RSVD});
      push_byte(8'hCC);
      // command frame too short for its long destination: bounds check fails
      push_req(ACT_BYTE, 1'b1, 8'd6, 8'hC0);
      push_byte({5'b00000, FTYPE_CMD});
      push_byte(8'h0C);
      push_byte(8'h5A);
      // clear with the other request fields set
      push_req(ACT_CLEAR, 1'b1, 8'hFF, 8'h7F);

      push_random_traffic(620);
      fill_phase = 1;
      fill_drain = 1'b1;
      push_random_traffic(1235);
      fill_phase = 2;
      fill_drain = 1'b1;
      push_random_traffic(1850);
      total_reqs = pending_reqs.size();

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // wait until all requests are taken and answered, then keep the clock running to catch extras
      while (reqs_taken < total_reqs || survey_exp_q.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (survey_exp_q.size() == 0 && error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
